// ----- sv/mbla_pkg.sv -----
package mbla_pkg;

    // Cleaned-up threshold constants
    localparam logic [7:0] DROP_RAW_UNSET  = 8'hFF;
    localparam logic [7:0] DROP_DEFAULT    = 8'd25;
    localparam logic [7:0] DROP_MIN        = 8'd10;
    localparam logic [7:0] DROP_MAX        = 8'd45;
    localparam logic [7:0] SWING_RAW_UNSET = 8'hFF;
    localparam logic [7:0] SWING_DEFAULT   = 8'd15;
    localparam logic [7:0] SWING_MAX       = 8'd100;
    localparam int         PCT_SCALE       = 100;

    // Both runs stop counting once they reach two, so two bits hold them
    localparam int         RUN_W      = 2;
    localparam logic [RUN_W-1:0] RUN_NEEDED = RUN_W'(2);
    localparam logic [RUN_W-1:0] RUN_SAT    = '1;

    // Configuration register indexes
    localparam int         CFG_IDX_W      = 2;
    localparam int         CFG_DATA_W     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_PCT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd2;

    // Item kinds
    localparam logic CMD_CYCLE = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] cycle_peak_current;
        logic [7:0]  revolution_count;
        logic        idle_flag;
        logic        revolution_mode;
        logic [15:0] swing_centiamps;
        logic        protection_tripped;
        logic        link_lost;
        logic [15:0] baseline_current;
        logic [7:0]  command_code;
    } item_t;

    typedef struct packed {
        logic alarm_latched;
        logic alarm_bit;
        logic ack_accepted;
    } result_t;

    typedef struct packed {
        logic [RUN_W-1:0] suspect_run;
        logic [RUN_W-1:0] recover_run;
        logic             latched;
        logic             reported;
    } state_t;

    typedef struct packed {
        logic [7:0] drop_pct_raw;
        logic [7:0] min_swing_raw;
        logic       alarm_enable;
    } cfg_t;

endpackage

// ----- sv/mbla_item_if.sv -----
interface mbla_item_if import mbla_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/mbla_result_if.sv -----
interface mbla_result_if import mbla_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/motor_blade_loss_alarm_core.sv -----
// Channel  Dir  Payload   Beat taken when
// item     in   item_t    item.valid && item.ready
// result   out  result_t  result.valid && result.ready
// cfg      in   idx/data  cfg_we high
//
// One item per clock sustained while the result side takes beats; a taken beat
// goes through the input register, then evaluation into the result register.
// Alarm state updates as a beat leaves the input register, so the next beat
// sees it. Reset clears state, counters and valid flags; config returns to
// its defaults. A stalled result holds its beat while the input register
// still takes one more beat; item.ready then drops until the result moves.
module motor_blade_loss_alarm_core import mbla_pkg::*; #(
    parameter logic [7:0] ACK_CODE = 8'd1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mbla_item_if.sink             item,
    mbla_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    cfg_t    cfg_reg;
    logic    out_free;
    logic    advance;

    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;

    assign result.valid = out_valid_reg;
    assign result.data  = result_reg;

    mbla_eval #(
        .ACK_CODE (ACK_CODE)
    ) u_eval (
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_item_reg <= item.data;
        if (advance)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drop_pct_raw  <= DROP_RAW_UNSET;
            cfg_reg.min_swing_raw <= SWING_RAW_UNSET;
            cfg_reg.alarm_enable  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DROP_PCT:  cfg_reg.drop_pct_raw  <= cfg_data;
                CFG_MIN_SWING: cfg_reg.min_swing_raw <= cfg_data;
                CFG_ENABLE:    cfg_reg.alarm_enable  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // reported bit is only ever set together with the latch
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.reported |-> state_reg.latched)
        else $error("reported alarm bit set without latch");

    // unlatched streak never sits at the latching count
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.latched |-> (state_reg.suspect_run < RUN_NEEDED))
        else $error("suspect streak reached limit without latching");

    // an acknowledge beat leaves everything cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.cmd == CMD_WRITE && in_item_reg.command_code == ACK_CODE)
        |=> (state_reg == '0 && result_reg.ack_accepted && !result_reg.alarm_latched))
        else $error("acknowledge did not clear alarm state");

    // state only moves when a beat is evaluated
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("alarm state changed without a beat");

    // input side only stalls while the input register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (in_valid_reg && out_valid_reg))
        else $error("item stalled with free storage");
`endif

endmodule

// ----- sv/mbla_eval.sv -----
module mbla_eval import mbla_pkg::*; #(
    parameter logic [7:0] ACK_CODE = 8'd1
) (
    input  item_t   item,
    input  cfg_t    cfg,
    input  state_t  state,
    output state_t  state_next,
    output result_t res
);

    logic [5:0]       drop_pct;
    logic [6:0]       min_swing;
    logic [21:0]      drop_prod;
    logic [23:0]      peak_scaled;
    logic             peak_low;
    logic             peak_ok;
    logic             suspect;
    logic             ack_hit;
    logic [RUN_W-1:0] run_inc;
    logic [RUN_W-1:0] rec_inc;
    state_t           cleared;

    always_comb
    begin
        if (cfg.drop_pct_raw == DROP_RAW_UNSET || cfg.drop_pct_raw < DROP_MIN)
            drop_pct = DROP_DEFAULT[5:0];
        else if (cfg.drop_pct_raw > DROP_MAX)
            drop_pct = DROP_MAX[5:0];
        else
            drop_pct = cfg.drop_pct_raw[5:0];

        if (cfg.min_swing_raw == SWING_RAW_UNSET || cfg.min_swing_raw == 8'd0)
            min_swing = SWING_DEFAULT[6:0];
        else if (cfg.min_swing_raw > SWING_MAX)
            min_swing = SWING_MAX[6:0];
        else
            min_swing = cfg.min_swing_raw[6:0];
    end

    // peak < floor(base*pct/100)  <=>  base*pct >= 100*(peak+1)
    assign drop_prod   = 22'(item.baseline_current) * 22'(drop_pct);
    assign peak_scaled = (24'(item.cycle_peak_current) + 24'd1) * 24'(PCT_SCALE);
    assign peak_low    = 24'(drop_prod) >= peak_scaled;
    // floor(base*50/100) is base halved
    assign peak_ok     = item.cycle_peak_current >= (item.baseline_current >> 1);

    assign suspect = (item.revolution_count == 8'd0) && item.idle_flag && peak_low
                     && (item.swing_centiamps <= 16'(min_swing));

    assign run_inc = (state.suspect_run == RUN_SAT) ? state.suspect_run
                                                    : state.suspect_run + RUN_W'(1);
    assign ack_hit = (item.command_code == ACK_CODE);

    always_comb
    begin
        cleared = '0;
        state_next = state;
        rec_inc = '0;
        res.ack_accepted = 1'b0;

        if (item.cmd == CMD_WRITE)
        begin
            if (ack_hit)
            begin
                state_next = cleared;
                res.ack_accepted = 1'b1;
            end
        end
        else if (item.revolution_mode && item.baseline_current != 16'd0)
        begin
            if (item.protection_tripped || item.link_lost)
            begin
                state_next.suspect_run = '0;
            end
            else if (state.latched)
            begin
                if (item.revolution_count != 8'd0 && peak_ok)
                    rec_inc = (state.recover_run == RUN_SAT) ? state.recover_run
                                                             : state.recover_run + RUN_W'(1);
                if (rec_inc >= RUN_NEEDED)
                    state_next = cleared;
                else
                    state_next.recover_run = rec_inc;
            end
            else if (suspect)
            begin
                state_next.suspect_run = run_inc;
                if (run_inc >= RUN_NEEDED)
                begin
                    state_next.latched  = 1'b1;
                    state_next.reported = cfg.alarm_enable;
                end
            end
            else
            begin
                state_next.suspect_run = '0;
            end
        end

        res.alarm_latched = state_next.latched;
        res.alarm_bit     = state_next.reported;
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import mbla_pkg::*;

    localparam logic [7:0] ACK_CMD     = 8'd1;
    localparam int         CLEAR_PCT   = 50;
    localparam int         LONG_HOLD   = 80;
    localparam int         STALL_LIMIT = 3000;
    localparam int         PER_SETTING = 138;

    // Golden model of the alarm plus the queue of results still owed by the block
    class alarm_scoreboard;
        cfg_t        cfg;
        logic [7:0]  ack_code;
        logic [7:0]  suspect_run;
        logic [7:0]  recover_run;
        logic        latched;
        logic        reported;
        result_t     owed[$];
        int          mismatches;
        int          checked;
        int          accepted;
        int          latch_count;
        int          ack_count;

        function new(logic [7:0] code);
            ack_code      = code;
            cfg.drop_pct_raw  = 8'd255;
            cfg.min_swing_raw = 8'd255;
            cfg.alarm_enable  = 1'b1;
            suspect_run   = '0;
            recover_run   = '0;
            latched       = 1'b0;
            reported      = 1'b0;
            mismatches    = 0;
            checked       = 0;
            accepted      = 0;
            latch_count   = 0;
            ack_count     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DROP_PCT:  cfg.drop_pct_raw  = data;
                CFG_MIN_SWING: cfg.min_swing_raw = data;
                CFG_ENABLE:    cfg.alarm_enable  = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned drop_pct();
            int unsigned p;
            p = cfg.drop_pct_raw;
            if (cfg.drop_pct_raw == DROP_RAW_UNSET || cfg.drop_pct_raw < DROP_MIN)
                p = DROP_DEFAULT;
            if (p > DROP_MAX)
                p = DROP_MAX;
            return p;
        endfunction

        function int unsigned min_swing();
            int unsigned s;
            s = cfg.min_swing_raw;
            if (cfg.min_swing_raw == SWING_RAW_UNSET || cfg.min_swing_raw == 8'd0)
                s = SWING_DEFAULT;
            if (s > SWING_MAX)
                s = SWING_MAX;
            return s;
        endfunction

        // the reported bit only follows the enable at the moment it is written
        function void write_reported(logic v);
            reported = cfg.alarm_enable ? v : 1'b0;
        endfunction

        function void clear_alarm();
            suspect_run = '0;
            recover_run = '0;
            latched     = 1'b0;
            write_reported(1'b0);
        endfunction

        function void evaluate_cycle(item_t it);
            int unsigned drop_thr;
            int unsigned clear_thr;
            logic        suspect;
            if (!it.revolution_mode || it.baseline_current == 16'd0)
                return;
            if (it.protection_tripped || it.link_lost) begin
                suspect_run = '0;
                return;
            end
            drop_thr  = (int'(it.baseline_current) * drop_pct()) / PCT_SCALE;
            clear_thr = (int'(it.baseline_current) * CLEAR_PCT) / PCT_SCALE;
            suspect = (it.revolution_count == 8'd0) && it.idle_flag &&
                      (it.cycle_peak_current < drop_thr) &&
                      (it.swing_centiamps <= min_swing());
            if (latched) begin
                if (it.revolution_count != 8'd0 && it.cycle_peak_current >= clear_thr) begin
                    if (recover_run != 8'd255)
                        recover_run++;
                end
                else
                    recover_run = '0;
                if (recover_run >= 8'd2)
                    clear_alarm();
                return;
            end
            if (suspect) begin
                if (suspect_run != 8'd255)
                    suspect_run++;
                if (suspect_run >= 8'd2) begin
                    latched = 1'b1;
                    latch_count++;
                    write_reported(1'b1);
                end
            end
            else
                suspect_run = '0;
        endfunction

        function void note_item(item_t it);
            result_t want;
            want.ack_accepted = 1'b0;
            accepted++;
            if (it.cmd == CMD_WRITE) begin
                if (it.command_code == ack_code) begin
                    clear_alarm();
                    want.ack_accepted = 1'b1;
                    ack_count++;
                end
            end
            else
                evaluate_cycle(it);
            want.alarm_latched = latched;
            want.alarm_bit     = reported;
            owed.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR @%0t: result beat %b with nothing owed", $time, got);
                return;
            end
            want = owed.pop_front();
            checked++;
            if (got.alarm_latched !== want.alarm_latched || got.alarm_bit !== want.alarm_bit ||
                got.ack_accepted !== want.ack_accepted) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR @%0t: result %0d latched %b/%b bit %b/%b ack %b/%b (exp/act)",
                             $time, checked, want.alarm_latched, got.alarm_latched,
                             want.alarm_bit, got.alarm_bit, want.ack_accepted, got.ack_accepted);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int src_idle_pct;
    int snk_idle_pct;
    // bumped by the stimulus each time a long hold-off is wanted
    int long_hold_req = 0;
    int stall_cycles = 0;

    alarm_scoreboard sb = new(ACK_CMD);

    mbla_item_if   item_bus ();
    mbla_result_if result_bus ();

    motor_blade_loss_alarm_core #(
        .ACK_CODE (ACK_CMD)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // beats are taken and checked on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && item_bus.valid && item_bus.ready)
            sb.note_item(item_bus.data);
        if (rst_n && result_bus.valid && result_bus.ready)
            sb.check_result(result_bus.data);
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
            $display("motor_blade_loss_alarm_core verification failed");
            $finish;
        end
    end

    // result side back-pressure, with an occasional long hold-off
    initial
    begin
        int hold_left;
        int seen_req;
        hold_left = 0;
        seen_req = 0;
        result_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req != seen_req) begin
                hold_left = LONG_HOLD;
                seen_req = long_hold_req;
            end
            if (hold_left != 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.data  <= it;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_bus.valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_setting(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DROP_PCT;
        cfg_data  <= c.drop_pct_raw;
        sb.set_reg(CFG_DROP_PCT, c.drop_pct_raw);
        @(negedge clk);
        cfg_index <= CFG_MIN_SWING;
        cfg_data  <= c.min_swing_raw;
        sb.set_reg(CFG_MIN_SWING, c.min_swing_raw);
        @(negedge clk);
        cfg_index <= CFG_ENABLE;
        cfg_data  <= {7'd0, c.alarm_enable};
        sb.set_reg(CFG_ENABLE, {7'd0, c.alarm_enable});
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic item_t make_cycle(int unsigned peak, int unsigned revs, logic idle,
                                         logic mode, int unsigned swing, logic prot,
                                         logic lost, int unsigned base);
        item_t it;
        it.cmd                = CMD_CYCLE;
        it.cycle_peak_current = peak[15:0];
        it.revolution_count   = revs[7:0];
        it.idle_flag          = idle;
        it.revolution_mode    = mode;
        it.swing_centiamps    = swing[15:0];
        it.protection_tripped = prot;
        it.link_lost          = lost;
        it.baseline_current   = base[15:0];
        it.command_code       = 8'($urandom);
        return it;
    endfunction

    // command write: every field but the kind and the code is junk
    function automatic item_t make_cmd(logic [7:0] code);
        logic [95:0] junk;
        item_t       it;
        junk = {$urandom, $urandom, $urandom};
        it = junk[$bits(item_t)-1:0];
        it.cmd          = CMD_WRITE;
        it.command_code = code;
        return it;
    endfunction

    function automatic item_t random_item();
        logic [95:0] junk;
        item_t       it;
        int unsigned roll, base, thr, clr, sw;
        roll = $urandom_range(99);
        base = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(65535, 40);
        thr  = base * sb.drop_pct() / PCT_SCALE;
        clr  = base * CLEAR_PCT / PCT_SCALE;
        sw   = sb.min_swing();
        it = make_cycle((thr > 0) ? $urandom_range(thr - 1, 0) : 0, 0, 1'b1, 1'b1,
                        $urandom_range(sw, 0), 1'b0, 1'b0, base);
        if (roll < 35) begin
            // suspect as built
        end
        else if (roll < 60) begin
            it.revolution_count   = 8'($urandom_range(255, 1));
            it.cycle_peak_current = 16'($urandom_range(65535, clr));
            it.idle_flag          = 1'($urandom);
            it.swing_centiamps    = 16'($urandom);
        end
        else if (roll < 70) begin
            // just outside one of the thresholds
            case ($urandom_range(4))
                0: it.cycle_peak_current = thr[15:0];
                1: it.swing_centiamps    = 16'(sw + 1);
                2: it.revolution_count   = 8'd1;
                3: it.idle_flag          = 1'b0;
                default: begin
                    it.revolution_count   = 8'($urandom_range(255, 1));
                    it.cycle_peak_current = (clr > 0) ? 16'(clr - 1) : 16'd0;
                end
            endcase
        end
        else if (roll < 76)
            {it.protection_tripped, it.link_lost} = 2'($urandom_range(3, 1));
        else if (roll < 80) begin
            if ($urandom_range(1))
                it.revolution_mode = 1'b0;
            else
                it.baseline_current = 16'd0;
        end
        else if (roll < 85)
            it = make_cmd(ACK_CMD);
        else if (roll < 88)
            it = make_cmd(8'(ACK_CMD + $urandom_range(255, 1)));
        else begin
            junk = {$urandom, $urandom, $urandom};
            it = junk[$bits(item_t)-1:0];
        end
        return it;
    endfunction

    initial
    begin
        cfg_t settings [6];
        int   s;
        int   n;
        settings = '{'{8'd255, 8'd255, 1'b1}, '{8'd10, 8'd1, 1'b1}, '{8'd45, 8'd100, 1'b0},
                     '{8'd9, 8'd0, 1'b1}, '{8'd46, 8'd101, 1'b0}, '{8'd0, 8'd254, 1'b1}};
        rst_n          = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.data  = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_DROP_PCT;
        cfg_data       = '0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: baseline 1000 gives drop 250, clear 500, swing 15
        send_item(make_cycle(10, 0, 1, 0, 0, 0, 0, 1000));         // mode off
        send_item(make_cycle(10, 0, 1, 1, 0, 0, 0, 0));            // no baseline yet
        send_item(make_cycle(249, 0, 1, 1, 15, 0, 0, 1000));
        send_item(make_cycle(249, 0, 1, 1, 15, 1, 0, 1000));       // trip clears streak
        send_item(make_cycle(249, 0, 1, 1, 15, 0, 0, 1000));
        send_item(make_cycle(250, 0, 1, 1, 15, 0, 0, 1000));       // peak on threshold
        send_item(make_cycle(249, 0, 1, 1, 15, 0, 0, 1000));
        send_item(make_cycle(0, 0, 1, 1, 0, 0, 0, 1000));          // latches
        send_item(make_cycle(500, 1, 0, 1, 900, 0, 0, 1000));
        send_item(make_cycle(0, 0, 1, 1, 0, 0, 1, 1000));          // link loss while latched
        send_item(make_cycle(499, 1, 0, 1, 900, 0, 0, 1000));      // just short of clear
        send_item(make_cycle(500, 1, 0, 1, 900, 0, 0, 1000));
        send_item(make_cycle(65535, 255, 1, 1, 65535, 0, 0, 1000)); // clears
        send_item(make_cycle(100, 0, 1, 1, 16, 0, 0, 1000));       // swing too wide
        send_item(make_cycle(0, 0, 1, 1, 0, 0, 0, 1000));
        send_item(make_cycle(0, 0, 1, 1, 0, 0, 0, 1000));
        send_item(make_cmd(8'hFF));
        send_item(make_cmd(ACK_CMD));
        send_item(make_cmd(ACK_CMD));
        send_item(make_cycle(65535, 255, 1, 1, 65535, 1, 1, 65535));
        send_item(make_cycle(0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cycle(16382, 0, 1, 1, 15, 0, 0, 65535));
        send_item(make_cycle(16382, 0, 1, 1, 15, 0, 0, 65535));
        send_item(make_cmd(8'd0));
        drain_results();

        for (s = 0; s < 6; s++) begin
            case (s / 2)
                0: begin src_idle_pct = 30; snk_idle_pct = 71; end
                1: begin src_idle_pct = 71; snk_idle_pct = 30; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            apply_setting(settings[s]);
            for (n = 0; n < PER_SETTING; n++) begin
                if (n == 40 && (s == 0 || s == 4))
                    long_hold_req++;
                if (n == 90 && s == 3)
                    drain_results();
                send_item(random_item());
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        $display("summary: %0d beats in, %0d results checked, %0d latches, %0d acknowledges",
                 sb.accepted, sb.checked, sb.latch_count, sb.ack_count);
        $display("summary: 6 register settings under three back-pressure regimes, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("motor_blade_loss_alarm_core verification clean");
        else
            $display("motor_blade_loss_alarm_core verification failed");
        $finish;
    end
endmodule
